[src/mlmt_pkg.sv]
package mlmt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int MASK_W    = 16;
    localparam int SLOT_W    = 4;

    localparam logic [2:0] OP_MIDI      = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
    localparam logic [2:0] OP_LEARN     = 3'd4;
    localparam logic [2:0] OP_CANCEL    = 3'd5;

    localparam logic [1:0] TYPE_CC   = 2'd0;
    localparam logic [1:0] TYPE_NOTE = 2'd1;
    localparam logic [1:0] TYPE_PC   = 2'd2;

    localparam logic [3:0] KIND_NOTE_ON = 4'h9;
    localparam logic [3:0] KIND_CC      = 4'hB;
    localparam logic [3:0] KIND_PC      = 4'hC;

    localparam logic [4:0] CHAN_MAX  = 5'd16;
    localparam logic [6:0] VALUE_MAX = 7'd127;

    typedef struct packed {
        logic [4:0] channel;
        logic [6:0] number;
        logic [1:0] mtype;
    } t_entry;

    typedef struct packed {
        logic   wr;
        logic   clr_one;
        logic   clr_all;
        t_entry entry;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mtype;
        logic [6:0] number;
        logic [4:0] channel;
    } t_key;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic              fire;
        logic [SLOT_W-1:0] slot;
    } t_tok;

endpackage

[src/mlmt_cell.sv]
module mlmt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mlmt_pkg::t_cmd              i_cmd,
    input  logic                        i_sel,
    input  logic                        i_present,
    input  logic [mlmt_pkg::SLOT_W-1:0] i_slot,
    input  mlmt_pkg::t_key              i_key,
    input  mlmt_pkg::t_tok              i_tok,
    output mlmt_pkg::t_tok              o_tok
);

    logic            r_valid;
    mlmt_pkg::t_entry r_entry;
    mlmt_pkg::t_tok   r_tok;
    logic            w_match;

    // One table entry; valid is cleared by reset, the fields only matter once written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr_all) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && i_sel) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr_one && i_sel) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_sel && !i_cmd.clr_all) begin
            r_entry <= i_cmd.entry;
        end
    end

    assign w_match = r_valid && (r_entry.mtype == i_key.mtype)
                     && (r_entry.number == i_key.number)
                     && ((r_entry.channel == 5'd0) || (r_entry.channel == i_key.channel));

    // The search token moves one cell per cycle; the first match claims it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        if (!i_tok.found && w_match) begin
            r_tok.found <= 1'b1;
            r_tok.fire  <= i_present;
            r_tok.slot  <= i_slot;
        end else begin
            r_tok.found <= i_tok.found;
            r_tok.fire  <= i_tok.fire;
            r_tok.slot  <= i_tok.slot;
        end
    end

    assign o_tok = r_tok;

endmodule

[src/midi_learn_mapping_table_unit.sv]
// One item at a time: a new item is accepted only once the last one has handed off its
// result. A recognized MIDI message item is scanned by the search token walking one cell
// per cycle; every other item goes straight from execute to done. A result still waiting
// in the output register holds the block.
// Reset (synchronous, active low) invalidates every mapping, drops any pending learn
// request, clears the slot mask and empties the output register.
module midi_learn_mapping_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    input  logic [3:0]  i_param_slot,
    input  logic [4:0]  i_map_channel,
    input  logic [6:0]  i_map_number,
    input  logic [1:0]  i_map_type,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_fire,
    output logic [3:0]  o_fire_slot,
    output logic [6:0]  o_fire_value,
    output logic        o_changed,
    output logic        o_learning,
    output logic [3:0]  o_learn_target,
    // Configuration write channel for the slot mask.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_slot_present_mask
);

    localparam int N = mlmt_pkg::NUM_SLOTS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    // Captured input item.
    logic [2:0] r_opcode;
    logic [7:0] r_status;
    logic [6:0] r_d1;
    logic [6:0] r_d2;
    logic [3:0] r_slot;
    logic [4:0] r_mch;
    logic [6:0] r_mnum;
    logic [1:0] r_mtype;

    logic [mlmt_pkg::MASK_W-1:0] r_mask;
    logic                        r_learn_pending;
    logic [3:0]                  r_learn_slot;
    logic                        r_launch;

    // Result being assembled.
    logic       r_res_fire;
    logic [3:0] r_res_slot;
    logic [6:0] r_res_value;
    logic       r_res_changed;

    // Output register.
    logic       r_out_valid;
    logic       r_out_fire;
    logic [3:0] r_out_slot;
    logic [6:0] r_out_value;
    logic       r_out_changed;
    logic       r_out_learning;
    logic [3:0] r_out_target;

    // Message classification of the captured item.
    logic           w_is_cc;
    logic           w_is_note;
    logic           w_is_pc;
    logic           w_msg_ok;
    logic [6:0]     w_msg_value;
    mlmt_pkg::t_key w_key;
    mlmt_pkg::t_cmd w_cmd;
    logic [3:0]     w_cmd_slot;
    logic           w_changed;
    logic           w_capture;
    logic           w_set_ok;
    logic           n_learn_pending;
    logic [3:0]     n_learn_slot;

    mlmt_pkg::t_tok w_tok [N+1];
    logic [N-1:0]   w_tok_valid;
    logic [N-1:0]   w_sel;
    logic [N-1:0]   w_present;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_slot_present_mask;
        end
    end

    function automatic logic slot_registered(input logic [3:0] slot,
                                             input logic [mlmt_pkg::MASK_W-1:0] mask);
        return (int'(slot) < mlmt_pkg::NUM_SLOTS) && mask[slot];
    endfunction

    // Classify the message: control change, note on with nonzero velocity, program change.
    always_comb begin
        w_is_cc     = (r_status[7:4] == mlmt_pkg::KIND_CC);
        w_is_note   = (r_status[7:4] == mlmt_pkg::KIND_NOTE_ON) && (r_d2 != 7'd0);
        w_is_pc     = (r_status[7:4] == mlmt_pkg::KIND_PC);
        w_msg_ok    = w_is_cc || w_is_note || w_is_pc;
        w_msg_value = w_is_pc ? mlmt_pkg::VALUE_MAX : r_d2;
        w_key.number  = r_d1;
        w_key.channel = {1'b0, r_status[3:0]} + 5'd1;
        if (w_is_cc) begin
            w_key.mtype = mlmt_pkg::TYPE_CC;
        end else if (w_is_note) begin
            w_key.mtype = mlmt_pkg::TYPE_NOTE;
        end else begin
            w_key.mtype = mlmt_pkg::TYPE_PC;
        end
    end

    // Table commands are issued only in the execute cycle; the cells apply them at its end.
    always_comb begin
        w_cmd           = '0;
        w_cmd_slot      = r_slot;
        w_changed       = 1'b0;
        n_learn_pending = r_learn_pending;
        n_learn_slot    = r_learn_slot;
        w_capture       = r_learn_pending && slot_registered(r_learn_slot, r_mask);
        w_set_ok        = (r_mtype <= mlmt_pkg::TYPE_PC) && slot_registered(r_slot, r_mask);
        if (r_state == S_EXEC) begin
            case (r_opcode)
                mlmt_pkg::OP_MIDI: begin
                    if (w_msg_ok && w_capture) begin
                        // Learn capture: the incoming message becomes the target's mapping.
                        w_cmd.wr            = 1'b1;
                        w_cmd.entry.channel = w_key.channel;
                        w_cmd.entry.number  = r_d1;
                        w_cmd.entry.mtype   = w_key.mtype;
                        w_cmd_slot          = r_learn_slot;
                        w_changed           = 1'b1;
                        n_learn_pending     = 1'b0;
                    end
                end
                mlmt_pkg::OP_SET: begin
                    if (w_set_ok) begin
                        w_cmd.wr            = 1'b1;
                        w_cmd.entry.channel = (r_mch > mlmt_pkg::CHAN_MAX) ?
                                              mlmt_pkg::CHAN_MAX : r_mch;
                        w_cmd.entry.number  = r_mnum;
                        w_cmd.entry.mtype   = r_mtype;
                        w_changed           = 1'b1;
                    end
                end
                mlmt_pkg::OP_CLEAR: begin
                    w_cmd.clr_one = 1'b1;
                    w_changed     = 1'b1;
                end
                mlmt_pkg::OP_CLEAR_ALL: begin
                    w_cmd.clr_all = 1'b1;
                    w_changed     = 1'b1;
                end
                mlmt_pkg::OP_LEARN: begin
                    n_learn_pending = 1'b1;
                    n_learn_slot    = r_slot;
                end
                mlmt_pkg::OP_CANCEL: begin
                    n_learn_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Token injected at the head of the chain in the cycle after execute, so the first cell
    // already holds any mapping that was just learned.
    assign w_tok[0] = '{valid: r_launch, found: 1'b0, fire: 1'b0, slot: '0};

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            if (gi < mlmt_pkg::MASK_W) begin : g_real
                assign w_sel[gi]     = (w_cmd_slot == mlmt_pkg::SLOT_W'(gi));
                assign w_present[gi] = r_mask[gi];
            end else begin : g_beyond
                assign w_sel[gi]     = 1'b0;
                assign w_present[gi] = 1'b0;
            end
            assign w_tok_valid[gi] = w_tok[gi+1].valid;
            mlmt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_sel     (w_sel[gi]),
                .i_present (w_present[gi]),
                .i_slot    (mlmt_pkg::SLOT_W'(gi)),
                .i_key     (w_key),
                .i_tok     (w_tok[gi]),
                .o_tok     (w_tok[gi+1])
            );
        end
    endgenerate

    // Sequencer: capture, execute, scan the chain for messages, then hand off the result.
    // The output register loads in the done state once it is empty or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_learn_pending <= 1'b0;
            r_learn_slot    <= '0;
            r_launch        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_launch <= (r_state == S_EXEC) && (r_opcode == mlmt_pkg::OP_MIDI) && w_msg_ok;
            if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_learn_pending <= n_learn_pending;
                    r_learn_slot    <= n_learn_slot;
                    if ((r_opcode == mlmt_pkg::OP_MIDI) && w_msg_ok) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_tok[N].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_fire     <= r_res_fire;
                        r_out_slot     <= r_res_slot;
                        r_out_value    <= r_res_fire ? r_res_value : 7'd0;
                        r_out_changed  <= r_res_changed;
                        r_out_learning <= r_learn_pending;
                        r_out_target   <= r_learn_slot;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_opcode <= i_opcode;
            r_status <= i_status_byte;
            r_d1     <= i_data_one;
            r_d2     <= i_data_two;
            r_slot   <= i_param_slot;
            r_mch    <= i_map_channel;
            r_mnum   <= i_map_number;
            r_mtype  <= i_map_type;
        end
        if (r_state == S_EXEC) begin
            r_res_fire    <= 1'b0;
            r_res_slot    <= '0;
            r_res_value   <= w_msg_value;
            r_res_changed <= w_changed;
        end
        if (r_state == S_SCAN && w_tok[N].valid) begin
            r_res_fire <= w_tok[N].fire;
            r_res_slot <= w_tok[N].fire ? w_tok[N].slot : 4'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fire         = r_out_fire;
    assign o_fire_slot    = r_out_slot;
    assign o_fire_value   = r_out_value;
    assign o_changed      = r_out_changed;
    assign o_learning     = r_out_learning;
    assign o_learn_target = r_out_target;

    // The scan token leaves the tail of the chain only while the sequencer waits for it.
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[N].valid |-> (r_state == S_SCAN))
        else $error("scan token left the chain outside the scan state");

    // A token is injected only right after the execute cycle.
    a_launch_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> ($past(r_state) == S_EXEC))
        else $error("scan token injected without an execute cycle");

    // At most one token travels the chain at a time.
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one scan token in the chain");

endmodule

[test/tb_midi_learn_mapping_table_unit.sv]
`timescale 1ns / 100ps

module tb_midi_learn_mapping_table_unit;

    // Codes that the package does not name but that the stimulus must reach.
    localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;
    localparam logic [1:0] TYPE_UNUSED    = 2'd3;
    localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [3:0] KIND_POLY_AT   = 4'hA;
    localparam logic [3:0] KIND_CHAN_AT   = 4'hD;
    localparam logic [3:0] KIND_BEND      = 4'hE;

    // Each side idles in about this many cycles out of a hundred.
    localparam int IDLE_PCT      = 29;
    // Long enough for a recognized message to walk the whole chain, with a margin.
    localparam int SETTLE_CYCLES = mlmt_pkg::NUM_SLOTS + 8;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_status_byte;
    logic [6:0]  i_data_one;
    logic [6:0]  i_data_two;
    logic [3:0]  i_param_slot;
    logic [4:0]  i_map_channel;
    logic [6:0]  i_map_number;
    logic [1:0]  i_map_type;
    logic        o_valid;
    logic        i_ready;
    logic        o_fire;
    logic [3:0]  o_fire_slot;
    logic [6:0]  o_fire_value;
    logic        o_changed;
    logic        o_learning;
    logic [3:0]  o_learn_target;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_slot_present_mask;

    // One result item as the block reports it.
    typedef struct packed {
        logic                        fire;
        logic [mlmt_pkg::SLOT_W-1:0] slot;
        logic [6:0]                  value;
        logic                        changed;
        logic                        learning;
        logic [mlmt_pkg::SLOT_W-1:0] target;
    } t_outcome;

    // Our own copy of the mapping table, the learn request and the slot mask.
    logic [mlmt_pkg::MASK_W-1:0] slot_mask;
    logic                        map_live [mlmt_pkg::NUM_SLOTS];
    mlmt_pkg::t_entry            map_table [mlmt_pkg::NUM_SLOTS];
    logic                        learn_armed;
    logic [mlmt_pkg::SLOT_W-1:0] learn_slot;

    // Outcomes predicted for accepted items, oldest first.
    t_outcome pending_outcomes[$];

    int   mismatches;
    int   checked_results;
    int   quiet_cycles;
    // When set, neither side idles: the long back-to-back stretch.
    logic steady;

    midi_learn_mapping_table_unit DUT (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_opcode                (i_opcode),
        .i_status_byte           (i_status_byte),
        .i_data_one              (i_data_one),
        .i_data_two              (i_data_two),
        .i_param_slot            (i_param_slot),
        .i_map_channel           (i_map_channel),
        .i_map_number            (i_map_number),
        .i_map_type              (i_map_type),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_fire                  (o_fire),
        .o_fire_slot             (o_fire_slot),
        .o_fire_value            (o_fire_value),
        .o_changed               (o_changed),
        .o_learning              (o_learning),
        .o_learn_target          (o_learn_target),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_slot_present_mask (i_cfg_slot_present_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side stalls at random, except during the steady stretch.
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Works out the outcome of the item accepted at this edge and updates the
    // table copy. A message is sorted into CC, note on with a nonzero velocity
    // or program change; anything else leaves the state alone. A pending learn
    // on a registered slot captures the message first, then the lowest valid
    // entry with the same key decides, and it fires only if its slot is
    // registered.
    task automatic compute_mapping_outcome();
        t_outcome          res;
        logic              known;
        logic              hit;
        logic [1:0]        msg_type;
        logic [4:0]        msg_chan;
        logic [6:0]        msg_value;
        res       = '0;
        known     = 1'b0;
        hit       = 1'b0;
        msg_type  = mlmt_pkg::TYPE_CC;
        msg_value = '0;
        msg_chan  = {1'b0, i_status_byte[3:0]} + 5'd1;
        case (i_opcode)
            mlmt_pkg::OP_MIDI: begin
                if (i_status_byte[7:4] == mlmt_pkg::KIND_CC) begin
                    known     = 1'b1;
                    msg_type  = mlmt_pkg::TYPE_CC;
                    msg_value = i_data_two;
                end else if (i_status_byte[7:4] == mlmt_pkg::KIND_NOTE_ON
                             && i_data_two != '0) begin
                    known     = 1'b1;
                    msg_type  = mlmt_pkg::TYPE_NOTE;
                    msg_value = i_data_two;
                end else if (i_status_byte[7:4] == mlmt_pkg::KIND_PC) begin
                    known     = 1'b1;
                    msg_type  = mlmt_pkg::TYPE_PC;
                    msg_value = mlmt_pkg::VALUE_MAX;
                end
                if (known) begin
                    if (learn_armed && slot_mask[learn_slot]) begin
                        map_live[learn_slot]  = 1'b1;
                        map_table[learn_slot] = mlmt_pkg::t_entry'{channel: msg_chan,
                                                                   number: i_data_one,
                                                                   mtype: msg_type};
                        learn_armed = 1'b0;
                        res.changed = 1'b1;
                    end
                    for (int s = 0; s < mlmt_pkg::NUM_SLOTS; s++) begin
                        if (!hit && map_live[s] && map_table[s].mtype == msg_type
                                && map_table[s].number == i_data_one
                                && (map_table[s].channel == '0
                                    || map_table[s].channel == msg_chan)) begin
                            hit = 1'b1;
                            if (slot_mask[s]) begin
                                res.fire  = 1'b1;
                                res.slot  = mlmt_pkg::SLOT_W'(s);
                                res.value = msg_value;
                            end
                        end
                    end
                end
            end
            mlmt_pkg::OP_SET: begin
                if (i_map_type != TYPE_UNUSED && slot_mask[i_param_slot]) begin
                    map_live[i_param_slot]  = 1'b1;
                    map_table[i_param_slot] = mlmt_pkg::t_entry'{
                        channel: (i_map_channel > mlmt_pkg::CHAN_MAX) ? mlmt_pkg::CHAN_MAX
                                                                      : i_map_channel,
                        number:  i_map_number,
                        mtype:   i_map_type};
                    res.changed = 1'b1;
                end
            end
            mlmt_pkg::OP_CLEAR: begin
                map_live[i_param_slot] = 1'b0;
                res.changed = 1'b1;
            end
            mlmt_pkg::OP_CLEAR_ALL: begin
                for (int s = 0; s < mlmt_pkg::NUM_SLOTS; s++) begin
                    map_live[s]  = 1'b0;
                    map_table[s] = '0;
                end
                res.changed = 1'b1;
            end
            mlmt_pkg::OP_LEARN: begin
                learn_armed = 1'b1;
                learn_slot  = i_param_slot;
            end
            mlmt_pkg::OP_CANCEL: begin
                learn_armed = 1'b0;
            end
            default: begin
            end
        endcase
        res.learning = learn_armed;
        res.target   = learn_slot;
        pending_outcomes.push_back(res);
    endtask

    // Compares the result item at this edge with the oldest outcome waiting.
    task automatic check_mapping_outcome();
        t_outcome want;
        t_outcome got;
        got = {o_fire, o_fire_slot, o_fire_value, o_changed, o_learning, o_learn_target};
        checked_results++;
        if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result %0d arrived with nothing expected: fire=%0d slot=%0d",
                         checked_results, got.fire, got.slot);
            end
        end else begin
            want = pending_outcomes.pop_front();
            if (got.fire !== want.fire || got.slot !== want.slot
                    || got.value !== want.value || got.changed !== want.changed
                    || got.learning !== want.learning || got.target !== want.target) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d expected fire=%0d slot=%0d value=%0d changed=%0d",
                             checked_results, want.fire, want.slot, want.value,
                             want.changed);
                    $display("    learning=%0d target=%0d; actual fire=%0d slot=%0d",
                             want.learning, want.target, got.fire, got.slot);
                    $display("    value=%0d changed=%0d learning=%0d target=%0d",
                             got.value, got.changed, got.learning, got.target);
                end
            end
        end
    endtask

    // Both channels are sampled at the edge, before any of this edge's updates
    // land. A result can never come in the cycle its item is accepted, so the
    // check and the prediction never touch the same entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                check_mapping_outcome();
            end
            if (i_valid && o_ready) begin
                compute_mapping_outcome();
            end
        end
    end

    // Watchdog: ends the run when nothing has moved on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one item and returns at the edge where it is accepted. Valid is
    // left high so that the next item can follow without a gap; it is only
    // lowered when a gap is chosen or the block is left to drain.
    task automatic send_item(input logic [2:0] op, input logic [7:0] status,
                             input logic [6:0] d1, input logic [6:0] d2,
                             input logic [3:0] slot, input logic [4:0] chan,
                             input logic [6:0] num, input logic [1:0] mtype);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_status_byte <= status;
        i_data_one    <= d1;
        i_data_two    <= d2;
        i_param_slot  <= slot;
        i_map_channel <= chan;
        i_map_number  <= num;
        i_map_type    <= mtype;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // A MIDI message; the command fields are don't-care and get random values.
    task automatic send_midi(input logic [7:0] status, input logic [6:0] d1,
                             input logic [6:0] d2);
        send_item(mlmt_pkg::OP_MIDI, status, d1, d2, 4'($urandom), 5'($urandom),
                  7'($urandom), 2'($urandom));
    endtask

    // A table or learn command; the message fields are don't-care.
    task automatic send_cmd(input logic [2:0] op, input logic [3:0] slot,
                            input logic [4:0] chan, input logic [6:0] num,
                            input logic [1:0] mtype);
        send_item(op, 8'($urandom), 7'($urandom), 7'($urandom), slot, chan, num, mtype);
    endtask

    // Lets the block run dry: every expected result in, then the latency margin.
    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the slot mask; only called while the block is idle.
    task automatic write_slot_mask(input logic [mlmt_pkg::MASK_W-1:0] mask);
        i_cfg_valid             <= 1'b1;
        i_cfg_slot_present_mask <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slot_mask = mask;
    endtask

    // Random item, weighted toward messages that hit live mappings so that
    // captures, first-match scans and fires happen often.
    task automatic send_random_item();
        int         pick;
        int         src;
        logic [3:0] kind;
        logic [3:0] chan_nib;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [4:0] chan;
        logic [6:0] num;
        logic [1:0] mtype;
        pick = $urandom_range(0, 99);
        src  = $urandom_range(0, mlmt_pkg::NUM_SLOTS - 1);
        num  = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
        if (pick < 52) begin
            if ($urandom_range(0, 99) < 60 && map_live[src]) begin
                case (map_table[src].mtype)
                    mlmt_pkg::TYPE_CC:   kind = mlmt_pkg::KIND_CC;
                    mlmt_pkg::TYPE_NOTE: kind = mlmt_pkg::KIND_NOTE_ON;
                    default:             kind = mlmt_pkg::KIND_PC;
                endcase
                chan_nib = (map_table[src].channel == '0) ? 4'($urandom)
                                                          : 4'(map_table[src].channel - 5'd1);
                status = {kind, chan_nib};
                d1     = map_table[src].number;
            end else if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0:       kind = mlmt_pkg::KIND_CC;
                    1:       kind = mlmt_pkg::KIND_NOTE_ON;
                    default: kind = mlmt_pkg::KIND_PC;
                endcase
                status = {kind, 4'($urandom)};
                d1     = num;
            end else begin
                status = 8'($urandom);
                d1     = 7'($urandom);
            end
            d2 = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom);
            send_midi(status, d1, d2);
        end else if (pick < 70) begin
            chan  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(0, 16));
            mtype = ($urandom_range(0, 19) == 0) ? TYPE_UNUSED : 2'($urandom_range(0, 2));
            send_cmd(mlmt_pkg::OP_SET, 4'(src), chan, num, mtype);
        end else if (pick < 77) begin
            send_cmd(mlmt_pkg::OP_CLEAR, 4'(src), 5'($urandom), 7'($urandom), 2'($urandom));
        end else if (pick < 79) begin
            send_cmd(mlmt_pkg::OP_CLEAR_ALL, 4'(src), 5'($urandom), 7'($urandom),
                     2'($urandom));
        end else if (pick < 90) begin
            send_cmd(mlmt_pkg::OP_LEARN, 4'(src), 5'($urandom), 7'($urandom), 2'($urandom));
        end else if (pick < 96) begin
            send_cmd(mlmt_pkg::OP_CANCEL, 4'(src), 5'($urandom), 7'($urandom), 2'($urandom));
        end else begin
            send_cmd(($urandom_range(0, 1) == 0) ? OP_SPARE_SIX : OP_SPARE_SEVEN,
                     4'(src), 5'($urandom), 7'($urandom), 2'($urandom));
        end
    endtask

    // Every opcode with every slot registered: field extremes, channel
    // saturation, the ignored message kinds, a learn capture and the clears.
    task automatic test_basic_mapping();
        write_slot_mask(16'hFFFF);
        send_midi({mlmt_pkg::KIND_CC, 4'h0}, 7'd0, 7'd0);           // empty table
        send_cmd(mlmt_pkg::OP_SET, 4'd0, 5'd0, 7'd127, mlmt_pkg::TYPE_CC);  // any channel
        send_cmd(mlmt_pkg::OP_SET, 4'd15, 5'd31, 7'd0, mlmt_pkg::TYPE_NOTE); // saturates
        send_cmd(mlmt_pkg::OP_SET, 4'd3, 5'd5, 7'd9, TYPE_UNUSED);  // bad type ignored
        send_cmd(mlmt_pkg::OP_SET, 4'd5, mlmt_pkg::CHAN_MAX, 7'd0, mlmt_pkg::TYPE_PC);
        send_midi({mlmt_pkg::KIND_CC, 4'h0}, 7'd127, 7'd127);
        send_midi({mlmt_pkg::KIND_CC, 4'h9}, 7'd127, 7'd0);
        send_midi({mlmt_pkg::KIND_NOTE_ON, 4'hF}, 7'd0, 7'd1);
        send_midi({mlmt_pkg::KIND_NOTE_ON, 4'hF}, 7'd0, 7'd0);      // velocity zero
        send_midi({mlmt_pkg::KIND_PC, 4'hF}, 7'd0, 7'd0);           // full scale
        send_midi(8'h7F, 7'd127, 7'd127);                           // data byte
        send_midi({KIND_NOTE_OFF, 4'hF}, 7'd0, 7'd64);
        send_midi({KIND_POLY_AT, 4'h0}, 7'd127, 7'd127);
        send_midi({KIND_CHAN_AT, 4'h0}, 7'd127, 7'd127);
        send_midi({KIND_BEND, 4'h0}, 7'd0, 7'd127);
        send_midi(8'hFF, 7'd0, 7'd0);
        send_cmd(mlmt_pkg::OP_LEARN, 4'd7, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_cmd(mlmt_pkg::OP_CANCEL, 4'd7, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_cmd(mlmt_pkg::OP_LEARN, 4'd7, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_midi({mlmt_pkg::KIND_CC, 4'h3}, 7'd10, 7'd64);         // captured, fires
        send_cmd(mlmt_pkg::OP_CLEAR, 4'd7, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_cmd(mlmt_pkg::OP_CLEAR, 4'd7, 5'd0, 7'd0, mlmt_pkg::TYPE_CC); // already empty
        send_cmd(OP_SPARE_SIX, 4'd0, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_cmd(OP_SPARE_SEVEN, 4'd15, 5'd31, 7'd127, TYPE_UNUSED);
        send_cmd(mlmt_pkg::OP_CLEAR_ALL, 4'd0, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
    endtask

    // Slots that lose their registration: the first match sits on an
    // unregistered slot and blocks a later registered one, a set is refused,
    // and a learn request on an unregistered slot stays pending.
    task automatic test_unregistered_slots();
        send_cmd(mlmt_pkg::OP_SET, 4'd2, 5'd0, 7'd20, mlmt_pkg::TYPE_CC);
        send_cmd(mlmt_pkg::OP_SET, 4'd4, 5'd0, 7'd20, mlmt_pkg::TYPE_CC);
        drain_block();
        write_slot_mask(16'h0010);
        send_midi({mlmt_pkg::KIND_CC, 4'h6}, 7'd20, 7'd33);
        send_cmd(mlmt_pkg::OP_SET, 4'd2, 5'd1, 7'd21, mlmt_pkg::TYPE_NOTE);
        send_cmd(mlmt_pkg::OP_LEARN, 4'd9, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_midi({mlmt_pkg::KIND_PC, 4'h2}, 7'd20, 7'd5);
        send_cmd(mlmt_pkg::OP_CLEAR, 4'd9, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        drain_block();
        write_slot_mask(16'h0000);
        send_cmd(mlmt_pkg::OP_SET, 4'd4, 5'd3, 7'd1, mlmt_pkg::TYPE_PC);
        send_cmd(mlmt_pkg::OP_LEARN, 4'd4, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
        send_midi({mlmt_pkg::KIND_NOTE_ON, 4'h1}, 7'd20, 7'd99);
        send_cmd(mlmt_pkg::OP_CANCEL, 4'd4, 5'd0, 7'd0, mlmt_pkg::TYPE_CC);
    endtask

    // One random phase under a fixed slot mask.
    task automatic test_random_traffic(input logic [mlmt_pkg::MASK_W-1:0] mask,
                                       input int count, input logic no_idle);
        drain_block();
        write_slot_mask(mask);
        steady = no_idle;
        repeat (count) send_random_item();
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        i_valid                 <= 1'b0;
        i_opcode                <= mlmt_pkg::OP_MIDI;
        i_status_byte           <= '0;
        i_data_one              <= '0;
        i_data_two              <= '0;
        i_param_slot            <= '0;
        i_map_channel           <= '0;
        i_map_number            <= '0;
        i_map_type              <= mlmt_pkg::TYPE_CC;
        i_cfg_valid             <= 1'b0;
        i_cfg_slot_present_mask <= '0;
        steady          = 1'b0;
        mismatches      = 0;
        checked_results = 0;
        quiet_cycles    = 0;
        // The copy starts from the reset state of the block.
        slot_mask   = '0;
        learn_armed = 1'b0;
        learn_slot  = '0;
        for (int s = 0; s < mlmt_pkg::NUM_SLOTS; s++) begin
            map_live[s]  = 1'b0;
            map_table[s] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_mapping();
        test_unregistered_slots();
        test_random_traffic(16'hFFFF, 400, 1'b1);
        test_random_traffic(16'($urandom), 400, 1'b0);
        test_random_traffic(16'h8001, 300, 1'b0);
        test_random_traffic(16'($urandom), 400, 1'b0);
        test_random_traffic(16'h0000, 150, 1'b0);
        test_random_traffic(16'hFFFF, 200, 1'b0);
        drain_block();

        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[midi_learn_mapping_table_unit.f]
src/mlmt_pkg.sv
src/mlmt_cell.sv
src/midi_learn_mapping_table_unit.sv
test/tb_midi_learn_mapping_table_unit.sv
